>>> hw/rtl/positional_list_engine_defines.svh
// Assertion macros for the positional list engine.
// The module that uses them must provide clk_i and rst_ni.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

`define PLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define PLE_ASSERT_NEVER(lbl, expr, msg) \
  `PLE_ASSERT(lbl, !(expr), msg)

`endif

>>> hw/rtl/ple_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned POS_W = 5;
  localparam int unsigned VAL_W = 31;
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] CMD_GET    = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [POS_W-1:0]  position;
    logic signed [31:0] item_value;
  } ple_in_t;

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] value;
  } ple_out_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } ple_ram_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/ple_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ple_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned DataW = 31
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/ple_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_engine_defines.svh"

module ple_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire ple_pkg::ple_in_t                in_data_i,
  output logic                                 in_stall_o,
  input  wire logic                            res_ready_i,
  output logic                                 res_valid_o,
  output ple_pkg::ple_out_t                    res_data_o,
  output ple_pkg::ple_ram_req_t                ram_req_o,
  input  wire logic [ple_pkg::VAL_W-1:0]       rdata_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_GET_WAIT = 4'd1;
  localparam logic [3:0] S_INS_RD   = 4'd2;
  localparam logic [3:0] S_INS_WR   = 4'd3;
  localparam logic [3:0] S_INS_LAST = 4'd4;
  localparam logic [3:0] S_FND_RD   = 4'd5;
  localparam logic [3:0] S_FND_CMP  = 4'd6;
  localparam logic [3:0] S_RM_ELEM  = 4'd7;
  localparam logic [3:0] S_RM_RD    = 4'd8;
  localparam logic [3:0] S_RM_WR    = 4'd9;
  localparam logic [3:0] S_RM_END   = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  localparam int unsigned CNT_W = ple_pkg::CNT_W;
  localparam int unsigned IDX_W = ple_pkg::IDX_W;
  localparam int unsigned VAL_W = ple_pkg::VAL_W;
  localparam int unsigned CMP_W = ple_pkg::CMP_W;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(ple_pkg::DEPTH);

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic             res_ok_q, res_ok_d;
  logic [VAL_W-1:0] res_val_q, res_val_d;

  // The one shared index unit: an increment or decrement of the walk index.
  logic [CNT_W-1:0] step_off;
  logic [CNT_W-1:0] step_sum;

  logic [CMP_W-1:0] in_pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             in_neg;
  logic             accept;

  assign in_pos_ext = CMP_W'(in_data_i.position);
  assign cnt_ext    = CMP_W'(count_q);
  assign in_neg     = in_data_i.item_value[31];
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    case (state_q)
      S_INS_RD, S_INS_WR: step_off = '1;
      default:            step_off = CNT_W'(1);
    endcase
  end

  assign step_sum = idx_q + step_off;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    val_d     = val_q;
    res_ok_d  = res_ok_q;
    res_val_d = res_val_q;
    ram_req_o = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d    = CNT_W'(in_data_i.position);
          val_d    = in_data_i.item_value[VAL_W-1:0];
          res_ok_d  = 1'b0;
          res_val_d = '0;
          state_d   = S_DONE;
          case (in_data_i.cmd)
            ple_pkg::CMD_GET: begin
              if (in_pos_ext < cnt_ext) begin
                ram_req_o.raddr = IDX_W'(in_data_i.position);
                state_d = S_GET_WAIT;
              end
            end
            ple_pkg::CMD_INSERT: begin
              if (!in_neg && (in_pos_ext <= cnt_ext) && (count_q != FULL)) begin
                idx_d   = count_q;
                state_d = (in_pos_ext == cnt_ext) ? S_INS_LAST : S_INS_RD;
              end
            end
            ple_pkg::CMD_FIND: begin
              if (!in_neg && (count_q != '0)) begin
                idx_d   = '0;
                state_d = S_FND_RD;
              end
            end
            default: begin
              if (in_pos_ext < cnt_ext) begin
                ram_req_o.raddr = IDX_W'(in_data_i.position);
                state_d = S_RM_ELEM;
              end
            end
          endcase
        end
      end
      S_GET_WAIT: begin
        res_ok_d  = 1'b1;
        res_val_d = rdata_i;
        state_d   = S_DONE;
      end
      S_INS_RD: begin
        ram_req_o.raddr = step_sum[IDX_W-1:0];
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        // Move the entry below the walk index up into it.
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q[IDX_W-1:0];
        ram_req_o.wdata = rdata_i;
        idx_d   = step_sum;
        state_d = (step_sum == pos_q) ? S_INS_LAST : S_INS_RD;
      end
      S_INS_LAST: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = pos_q[IDX_W-1:0];
        ram_req_o.wdata = val_q;
        count_d   = count_q + CNT_W'(1);
        res_ok_d  = 1'b1;
        res_val_d = VAL_W'(1);
        state_d   = S_DONE;
      end
      S_FND_RD: begin
        ram_req_o.raddr = idx_q[IDX_W-1:0];
        state_d = S_FND_CMP;
      end
      S_FND_CMP: begin
        if (rdata_i == val_q) begin
          res_ok_d  = 1'b1;
          res_val_d = VAL_W'(idx_q);
          state_d   = S_DONE;
        end else if (step_sum == count_q) begin
          state_d = S_DONE;
        end else begin
          idx_d   = step_sum;
          state_d = S_FND_RD;
        end
      end
      S_RM_ELEM: begin
        res_ok_d  = 1'b1;
        res_val_d = rdata_i;
        idx_d     = pos_q;
        state_d   = S_RM_RD;
      end
      S_RM_RD: begin
        // Once the entry above the index lies past the end, the gap is closed.
        if (step_sum == count_q) begin
          state_d = S_RM_END;
        end else begin
          ram_req_o.raddr = step_sum[IDX_W-1:0];
          state_d = S_RM_WR;
        end
      end
      S_RM_WR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q[IDX_W-1:0];
        ram_req_o.wdata = rdata_i;
        idx_d   = step_sum;
        state_d = S_RM_RD;
      end
      S_RM_END: begin
        count_d = count_q - CNT_W'(1);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    res_ok_q  <= res_ok_d;
    res_val_q <= res_val_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign res_valid_o      = (state_q == S_DONE);
  assign res_data_o.ok    = res_ok_q;
  assign res_data_o.value = res_val_q;

  `PLE_ASSERT(count_in_range_a, count_q <= FULL, "entry count exceeds the store depth")
  `PLE_ASSERT_NEVER(idle_write_a, (state_q == S_IDLE) && ram_req_o.we, "store written while idle")
  `PLE_ASSERT(done_release_a, (state_q == S_DONE) && res_ready_i |=> state_q == S_IDLE, "result transfer did not release the sequencer")
  `PLE_ASSERT(insert_count_a, state_q == S_INS_LAST |=> count_q == $past(count_q) + CNT_W'(1), "insert did not grow the list")
  `PLE_ASSERT(remove_count_a, state_q == S_RM_END |=> count_q == $past(count_q) - CNT_W'(1), "remove did not shrink the list")

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_engine.sv
// Insert and remove take longer the more entries lie between the position and the list end;
// find takes longer the further it searches; get and rejected commands need no walk.
// Throughput: one item at a time; input stalls until the result is handed on.
// The walk reads each entry, then moves or compares it, through the single store port pair.
// Reset (asynchronous, active low) empties the list; store contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire ple_pkg::ple_in_t  in_data_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output ple_pkg::ple_out_t      out_data_o,
  input  wire logic              out_stall_i
);

  ple_pkg::ple_ram_req_t             ram_req;
  logic [ple_pkg::VAL_W-1:0]         ram_rdata;
  logic                              res_valid;
  logic                              res_ready;
  ple_pkg::ple_out_t                 res_data;
  logic                              out_valid_q;
  ple_pkg::ple_out_t                 out_data_q;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .ram_req_o   (ram_req),
    .rdata_i     (ram_rdata)
  );

  ple_ram #(
    .Depth (ple_pkg::DEPTH),
    .AddrW (ple_pkg::IDX_W),
    .DataW (ple_pkg::VAL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // The output register takes a new result once the previous one has been transferred.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> sim/ple_list_checker.sv
`timescale 1ns / 1ps

module ple_list_checker
  import ple_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  ple_in_t     in_data_i,
  input  logic        in_stall_i,
  input  logic        out_valid_i,
  input  ple_out_t    out_data_i,
  input  logic        out_stall_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [VAL_W-1:0] list_entries [DEPTH];
  int unsigned      list_len = 0;
  ple_out_t         reply_q [$];
  int unsigned      fail_count = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = reply_q.size();

  // Applies one command to the shadow list and returns the reply it should give.
  function automatic ple_out_t update_list(input ple_in_t req);
    ple_out_t         reply;
    int unsigned      pos;
    logic             negative;
    logic [VAL_W-1:0] val;
    int unsigned      i;
    reply    = '0;
    pos      = 32'(req.position);
    negative = req.item_value[31];
    val      = req.item_value[VAL_W-1:0];
    case (req.cmd)
      CMD_GET: begin
        if (pos < list_len) begin
          reply.ok    = 1'b1;
          reply.value = list_entries[IDX_W'(pos)];
        end
      end
      CMD_INSERT: begin
        if (!negative && pos <= list_len && list_len < DEPTH) begin
          for (i = list_len; i > pos; i--) begin
            list_entries[IDX_W'(i)] = list_entries[IDX_W'(i-1)];
          end
          list_entries[IDX_W'(pos)] = val;
          list_len++;
          reply.ok    = 1'b1;
          reply.value = VAL_W'(1);
        end
      end
      CMD_FIND: begin
        if (!negative) begin
          for (i = 0; i < list_len && !reply.ok; i++) begin
            if (list_entries[IDX_W'(i)] == val) begin
              reply.ok    = 1'b1;
              reply.value = VAL_W'(i);
            end
          end
        end
      end
      default: begin
        if (pos < list_len) begin
          reply.ok    = 1'b1;
          reply.value = list_entries[IDX_W'(pos)];
          for (i = pos; i + 1 < list_len; i++) begin
            list_entries[IDX_W'(i)] = list_entries[IDX_W'(i+1)];
          end
          list_len--;
        end
      end
    endcase
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ple_out_t want;
    if (!rst_ni) begin
      list_len = 0;
      reply_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) reply_q.push_back(update_list(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result transfer with nothing outstanding: ok=%0b value=%0d",
                   $time, out_data_i.ok, out_data_i.value);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (out_data_i.ok !== want.ok) begin
            $display("%0t: ok mismatch: expected %0b, actual %0b",
                     $time, want.ok, out_data_i.ok);
            fail_count++;
          end
          if (out_data_i.value !== want.value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d",
                     $time, want.value, out_data_i.value);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ple_pkg::*;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  ple_in_t     in_data   = '0;
  logic        in_stall;
  logic        out_valid;
  ple_out_t    out_data;
  logic        out_stall = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_pct  = 14;
  int unsigned stall_pct = 67;

  positional_list_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_stall_i (out_stall)
  );

  ple_list_checker u_list_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_data_i    (in_data),
    .in_stall_i   (in_stall),
    .out_valid_i  (out_valid),
    .out_data_i   (out_data),
    .out_stall_i  (out_stall),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Mostly small values so that finds hit and duplicates occur.
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return $urandom | 32'h8000_0000;
    if (r < 25) return $urandom & 32'h7FFF_FFFF;
    if (r < 30) return 32'h7FFF_FFFF;
    return $urandom_range(7);
  endfunction

  task automatic send_command(input logic [1:0] cmd, input int unsigned pos,
                              input logic [31:0] val);
    ple_in_t req;
    req.cmd        = cmd;
    req.position   = pos[POS_W-1:0];
    req.item_value = val;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (in_stall);
  endtask

  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    logic [1:0]  cmd;
    int unsigned pos;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Failures on the empty list.
    send_command(CMD_GET, 0, 32'h0);
    send_command(CMD_REMOVE, 0, 32'hFFFF_FFFF);
    send_command(CMD_FIND, 0, 32'h0);
    send_command(CMD_INSERT, 1, 32'h5);
    send_command(CMD_INSERT, 0, 32'h8000_0000);
    // Fill the store, inserting at the front, at the end and in the middle.
    for (k = 0; k < DEPTH; k++) begin
      pos = (k % 3 == 0) ? 0 : (k % 3 == 1) ? k : k / 2;
      send_command(CMD_INSERT, pos, (k == 1) ? 32'h7FFF_FFFF : k % 5);
    end
    send_command(CMD_INSERT, DEPTH, 32'h1);
    send_command(CMD_GET, DEPTH, 32'h0);
    send_command(CMD_FIND, 31, 32'h3);
    send_command(CMD_FIND, 0, 32'hFFFF_FFFF);

    for (n = 0; n < 650; n++) begin
      if (n == 220) begin
        idle_pct  = 67;
        stall_pct = 14;
      end else if (n == 440) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      pick = $urandom_range(99);
      // Alternate between growing and shrinking so the list runs full and empty.
      if (((n / 60) % 2) == 0) begin
        cmd = (pick < 20) ? CMD_GET : (pick < 65) ? CMD_INSERT :
              (pick < 80) ? CMD_FIND : CMD_REMOVE;
      end else begin
        cmd = (pick < 20) ? CMD_GET : (pick < 35) ? CMD_INSERT :
              (pick < 55) ? CMD_FIND : CMD_REMOVE;
      end
      pos = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(DEPTH);
      send_command(cmd, pos, pick_value());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS positional_list_engine");
    end else begin
      $display("FAIL positional_list_engine");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL positional_list_engine");
    $finish;
  end

endmodule
